// ===== hw/rtl/idr_pkg.sv =====
// shared types and constants for the inertial dead reckoning step unit
package idr_pkg;

  localparam int ACC_W = 80;
  localparam logic [9:0] DIV_K = 10'd1000;
  localparam logic [5:0] DIV_LAST = 6'd63;

  typedef enum logic [1:0] {
    REG_VEL_SCALE = 2'd0,
    REG_JUMP_THR  = 2'd1,
    REG_POS_WT    = 2'd2,
    REG_RNG_WT    = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GLD,
    ST_GRAV,
    ST_GFIN,
    ST_TT,
    ST_TFIN,
    ST_UU,
    ST_UFIN,
    ST_DV,
    ST_DVFIN,
    ST_PP,
    ST_PFIN,
    ST_DP,
    ST_DPFIN,
    ST_FCHK,
    ST_FUSE,
    ST_FFIN,
    ST_OUT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [31:0] r;
    if (x > 80'sd2147483647) r = 32'sh7fffffff;
    else if (x < -80'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/inertial_dead_reckoning_step_unit.sv =====
// top level of the inertial dead reckoning step unit
// usage:
//   input channel (in_valid/in_ready) takes one word per sample: quaternion,
//   acceleration, millisecond stamp and ultrasonic range
//   output channel (out_valid/out_ready) returns one word per sample: velocity,
//   position and the skipped flag
//   apb port writes velocity_scale, range_jump_threshold, position_weight and
//   range_weight at byte addresses 0, 4, 8, 12; reads return them
// sequence: a skipped sample goes from idle straight to the output state, where its
//   result word is registered; any other sample runs each axis through the
//   bit-serial multiplier (one multiplier bit a cycle) and the radix-2 divide by
//   1000 (six divides per sample), and range fusion is added when the range jumps
// throughput: one sample at a time; in_ready is high only while idle
// reset: synchronous; state, config, history, vel, pos and out_valid are reset
// stall: a finished word waits in the output register; the unit accepts the
//   next sample and only holds before its own result if the old one is unread
module inertial_dead_reckoning_step_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [31:0] in_accel_x,
  input  logic signed [31:0] in_accel_y,
  input  logic signed [31:0] in_accel_z,
  input  logic        [15:0] in_time_ms,
  input  logic signed [31:0] in_range,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic signed [31:0] out_vel_z,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic               out_skipped,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [3:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);
  import idr_pkg::*;

  state_t state_r, state_nxt;

  logic signed [31:0] vscale_r;
  logic [30:0] thr_r;
  logic [17:0] pw_r, rw_r;

  logic [15:0] last_stamp_r, last_stamp_nxt;
  logic signed [31:0] last_range_r, last_range_nxt;
  logic signed [31:0] vel_r [3];
  logic signed [31:0] vel_nxt [3];
  logic signed [31:0] pos_r [3];
  logic signed [31:0] pos_nxt [3];

  logic signed [15:0] q_r [4];
  logic signed [15:0] q_nxt [4];
  logic signed [31:0] a_r [3];
  logic signed [31:0] a_nxt [3];
  logic signed [31:0] range_r, range_nxt;
  logic [16:0] d_r, d_nxt;
  logic skip_r, skip_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [1:0] k_r, k_nxt;

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ACC_W-1:0] mca_r, mca_nxt;
  logic [31:0] mcb_r, mcb_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [5:0] lim_r, lim_nxt;
  logic [63:0] dvd_r, dvd_nxt;
  logic [9:0] rem_r, rem_nxt;
  logic dneg_r, dneg_nxt;

  logic out_valid_r, out_valid_nxt;
  logic signed [31:0] ovel_r [3];
  logic signed [31:0] ovel_nxt [3];
  logic signed [31:0] opos_r [3];
  logic signed [31:0] opos_nxt [3];
  logic oskip_r, oskip_nxt;

  logic mul_last, div_last, grav_last, fuse_last, jump, out_load, cfg_wr;
  logic signed [ACC_W-1:0] mul_term;
  logic signed [39:0] g_c;
  logic signed [40:0] ad_c;
  logic signed [31:0] accv_c;
  logic signed [ACC_W-1:0] quo_c;
  logic signed [31:0] vel_new_c, pos_new_c, fuse_c;
  logic signed [32:0] rdiff_c;
  logic [32:0] rabs_c;

  assign mul_last  = (cnt_r == lim_r);
  assign div_last  = (cnt_r == DIV_LAST);
  assign grav_last = (axis_r == 2'd2) ? (k_r == 2'd3) : (k_r == 2'd1);
  assign fuse_last = (k_r == 2'd1);
  assign mul_term  = mcb_r[0] ? mca_r : '0;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign cfg_wr    = psel && penable && pwrite && pready;

  assign g_c = (axis_r == 2'd2) ? (($signed(acc_r[39:0]) + 40'sd2048) >>> 12)
                                : (($signed(acc_r[39:0]) + 40'sd1024) >>> 11);
  assign ad_c = 41'(a_r[axis_r]) - 41'(g_c);
  assign accv_c = sat32(ACC_W'(ad_c));
  assign quo_c = dneg_r ? -(ACC_W'({1'b0, dvd_r}) + ACC_W'(rem_r != 10'd0))
                        : ACC_W'({1'b0, dvd_r});
  assign vel_new_c = sat32(ACC_W'(vel_r[axis_r]) + quo_c);
  assign pos_new_c = sat32(ACC_W'(pos_r[axis_r]) + quo_c);
  assign fuse_c = sat32((acc_r + ACC_W'(32768)) >>> 16);
  assign rdiff_c = 33'(range_r) - 33'(last_range_r);
  assign rabs_c = rdiff_c[32] ? 33'(-rdiff_c) : 33'(rdiff_c);
  assign jump = rabs_c > {2'b00, thr_r};

  assign pready = 1'b1;
  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_VEL_SCALE: prdata = vscale_r;
      REG_JUMP_THR:  prdata = {1'b0, thr_r};
      REG_POS_WT:    prdata = {14'd0, pw_r};
      REG_RNG_WT:    prdata = {14'd0, rw_r};
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = (in_time_ms == last_stamp_r) ? ST_OUT : ST_GLD;
      ST_GLD:   state_nxt = ST_GRAV;
      ST_GRAV:  if (mul_last && grav_last) state_nxt = ST_GFIN;
      ST_GFIN:  state_nxt = ST_TT;
      ST_TT:    if (mul_last) state_nxt = ST_TFIN;
      ST_TFIN:  state_nxt = ST_UU;
      ST_UU:    if (mul_last) state_nxt = ST_UFIN;
      ST_UFIN:  state_nxt = ST_DV;
      ST_DV:    if (div_last) state_nxt = ST_DVFIN;
      ST_DVFIN: state_nxt = ST_PP;
      ST_PP:    if (mul_last) state_nxt = ST_PFIN;
      ST_PFIN:  state_nxt = ST_DP;
      ST_DP:    if (div_last) state_nxt = ST_DPFIN;
      ST_DPFIN: state_nxt = (axis_r == 2'd2) ? ST_FCHK : ST_GLD;
      ST_FCHK:  state_nxt = jump ? ST_FUSE : ST_OUT;
      ST_FUSE:  if (mul_last && fuse_last) state_nxt = ST_FFIN;
      ST_FFIN:  state_nxt = ST_OUT;
      ST_OUT:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    logic signed [ACC_W-1:0] ld_a;
    logic [31:0] ld_b;
    logic [5:0] ld_lim;
    logic ld_neg, ld;
    logic [10:0] dtry;
    logic dge;
    logic signed [64:0] dx;

    in_ready = (state_r == ST_IDLE);
    out_valid_nxt = out_valid_r && !out_ready;
    ovel_nxt = ovel_r;
    opos_nxt = opos_r;
    oskip_nxt = oskip_r;
    last_stamp_nxt = last_stamp_r;
    last_range_nxt = last_range_r;
    vel_nxt = vel_r;
    pos_nxt = pos_r;
    q_nxt = q_r;
    a_nxt = a_r;
    range_nxt = range_r;
    d_nxt = d_r;
    skip_nxt = skip_r;
    axis_nxt = axis_r;
    k_nxt = k_r;
    acc_nxt = acc_r;
    mca_nxt = mca_r;
    mcb_nxt = mcb_r;
    cnt_nxt = cnt_r;
    lim_nxt = lim_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    dneg_nxt = dneg_r;
    ld_a = '0;
    ld_b = '0;
    ld_lim = '0;
    ld_neg = 1'b0;
    dx = '0;

    // shift-add multiplier, msb of the multiplier digit has negative weight
    if (state_r inside {ST_GRAV, ST_TT, ST_UU, ST_PP, ST_FUSE}) begin
      acc_nxt = mul_last ? acc_r - mul_term : acc_r + mul_term;
      mca_nxt = mca_r <<< 1;
      mcb_nxt = mcb_r >> 1;
      cnt_nxt = cnt_r + 6'd1;
      if (mul_last) k_nxt = k_r + 2'd1;
    end

    // restoring divide by 1000, one quotient bit a cycle
    dtry = {rem_r, dvd_r[63]};
    dge = (dtry >= {1'b0, DIV_K});
    if (state_r inside {ST_DV, ST_DP}) begin
      rem_nxt = dge ? 10'(dtry - {1'b0, DIV_K}) : dtry[9:0];
      dvd_nxt = {dvd_r[62:0], dge};
      cnt_nxt = cnt_r + 6'd1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          q_nxt[0] = in_quat_w;
          q_nxt[1] = in_quat_x;
          q_nxt[2] = in_quat_y;
          q_nxt[3] = in_quat_z;
          a_nxt[0] = in_accel_x;
          a_nxt[1] = in_accel_y;
          a_nxt[2] = in_accel_z;
          range_nxt = in_range;
          d_nxt = {1'b0, 16'(in_time_ms - last_stamp_r)};
          skip_nxt = (in_time_ms == last_stamp_r);
          axis_nxt = 2'd0;
        end
      end
      ST_UFIN: begin
        dx = 65'($signed(acc_r[79:16])) + 65'sd500;
        dneg_nxt = dx[64];
        dvd_nxt = dx[64] ? 64'(-dx) : dx[63:0];
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      ST_DVFIN: vel_nxt[axis_r] = vel_new_c;
      ST_PFIN: begin
        dx = 65'(acc_r) + 65'sd500;
        dneg_nxt = dx[64];
        dvd_nxt = dx[64] ? 64'(-dx) : dx[63:0];
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      ST_DPFIN: begin
        pos_nxt[axis_r] = pos_new_c;
        axis_nxt = axis_r + 2'd1;
      end
      ST_FFIN: pos_nxt[2] = fuse_c;
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          ovel_nxt = vel_r;
          opos_nxt = pos_r;
          oskip_nxt = skip_r;
          if (!skip_r) begin
            last_stamp_nxt = 16'(d_r[15:0] + last_stamp_r);
            last_range_nxt = range_r;
          end
        end
      end
      default: ;
    endcase

    if (state_nxt != state_r) k_nxt = '0;

    // operand load for the multiply about to run
    ld = (state_nxt inside {ST_GRAV, ST_TT, ST_UU, ST_PP, ST_FUSE}) &&
         ((state_nxt != state_r) || mul_last);
    case (state_nxt)
      ST_GRAV: begin
        ld_lim = 6'd15;
        case ({axis_r, k_nxt})
          4'b00_00: begin ld_a = ACC_W'(q_r[1]); ld_b = 32'(unsigned'(q_r[3])); end
          4'b00_01: begin
            ld_a = ACC_W'(q_r[0]); ld_b = 32'(unsigned'(q_r[2])); ld_neg = 1'b1;
          end
          4'b01_00: begin ld_a = ACC_W'(q_r[0]); ld_b = 32'(unsigned'(q_r[1])); end
          4'b01_01: begin ld_a = ACC_W'(q_r[2]); ld_b = 32'(unsigned'(q_r[3])); end
          4'b10_00: begin ld_a = ACC_W'(q_r[0]); ld_b = 32'(unsigned'(q_r[0])); end
          4'b10_01: begin
            ld_a = ACC_W'(q_r[1]); ld_b = 32'(unsigned'(q_r[1])); ld_neg = 1'b1;
          end
          4'b10_10: begin
            ld_a = ACC_W'(q_r[2]); ld_b = 32'(unsigned'(q_r[2])); ld_neg = 1'b1;
          end
          default: begin ld_a = ACC_W'(q_r[3]); ld_b = 32'(unsigned'(q_r[3])); end
        endcase
      end
      ST_TT: begin
        ld_a = ACC_W'(accv_c);
        ld_b = 32'(d_r);
        ld_lim = 6'd16;
      end
      ST_UU: begin
        ld_a = acc_r;
        ld_b = vscale_r;
        ld_lim = 6'd31;
      end
      ST_PP: begin
        ld_a = ACC_W'(vel_new_c);
        ld_b = 32'(d_r);
        ld_lim = 6'd16;
      end
      ST_FUSE: begin
        ld_lim = 6'd18;
        if (k_nxt == 2'd0) begin
          ld_a = ACC_W'(pos_r[2]);
          ld_b = 32'(pw_r);
        end else begin
          ld_a = ACC_W'(range_r);
          ld_b = 32'(rw_r);
        end
      end
      default: ;
    endcase
    if (ld) begin
      mca_nxt = ld_neg ? -ld_a : ld_a;
      mcb_nxt = ld_b;
      lim_nxt = ld_lim;
      cnt_nxt = '0;
      if (state_nxt != state_r) acc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vscale_r <= 32'sd65536;
      thr_r <= 31'd6554;
      pw_r <= 18'd52429;
      rw_r <= 18'd13107;
      last_stamp_r <= '0;
      last_range_r <= '0;
      for (int i = 0; i < 3; i++) begin
        vel_r[i] <= '0;
        pos_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
      axis_r <= '0;
      k_r <= '0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        unique case (reg_idx_t'(paddr[3:2]))
          REG_VEL_SCALE: vscale_r <= pwdata;
          REG_JUMP_THR:  thr_r <= pwdata[30:0];
          REG_POS_WT:    pw_r <= pwdata[17:0];
          REG_RNG_WT:    rw_r <= pwdata[17:0];
          default: ;
        endcase
      end
      last_stamp_r <= last_stamp_nxt;
      last_range_r <= last_range_nxt;
      vel_r <= vel_nxt;
      pos_r <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      axis_r <= axis_nxt;
      k_r <= k_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    a_r <= a_nxt;
    range_r <= range_nxt;
    d_r <= d_nxt;
    skip_r <= skip_nxt;
    acc_r <= acc_nxt;
    mca_r <= mca_nxt;
    mcb_r <= mcb_nxt;
    lim_r <= lim_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dneg_r <= dneg_nxt;
    ovel_r <= ovel_nxt;
    opos_r <= opos_nxt;
    oskip_r <= oskip_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_vel_x = ovel_r[0];
  assign out_vel_y = ovel_r[1];
  assign out_vel_z = ovel_r[2];
  assign out_pos_x = opos_r[0];
  assign out_pos_y = opos_r[1];
  assign out_pos_z = opos_r[2];
  assign out_skipped = oskip_r;

endmodule
